// ----- rtl/keyed_fixed_window_rate_limiter_unit_assert.svh -----
// assertion macros for the keyed fixed-window rate limiter
`ifndef KEYED_FIXED_WINDOW_RATE_LIMITER_UNIT_ASSERT_SVH
`define KEYED_FIXED_WINDOW_RATE_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define KFWRL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define KFWRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/kfwrl_pkg.sv -----
// shared types and constants of the keyed fixed-window rate limiter
package kfwrl_pkg;

	localparam int USER_W    = 16;
	localparam int CHAN_W    = 16;
	localparam int TIME_W    = 32;
	localparam int COUNT_W   = 16;
	localparam int LIMIT_W   = 8;
	localparam int WIN_W     = 10;
	localparam int REMOVED_W = 7;

	localparam logic [LIMIT_W-1:0]   LIMIT_MIN   = 8'd1;
	localparam logic [WIN_W-1:0]     WINDOW_MIN  = 10'd1;
	localparam logic [WIN_W-1:0]     WINDOW_MAX  = 10'd999;
	localparam logic [REMOVED_W-1:0] REMOVED_MAX = 7'd127;
	localparam logic [COUNT_W-1:0]   COUNT_ONE   = 16'd1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef enum logic [1:0] {
		CMD_CHECK  = 2'd0,
		CMD_RECORD = 2'd1,
		CMD_SWEEP  = 2'd2,
		CMD_DROP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_UPDATE
	} eng_state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [USER_W-1:0]  user;
		logic [CHAN_W-1:0]  chan;
		logic [TIME_W-1:0]  now;
		logic [LIMIT_W-1:0] limit;
		logic [WIN_W-1:0]   win;
		logic               throttle_en;
		logic               record_en;
		logic               sweep_hold;
	} job_t;

	typedef struct packed {
		logic               valid;
		logic [USER_W-1:0]  user;
		logic [CHAN_W-1:0]  chan;
		logic [TIME_W-1:0]  start;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic                 throttled;
		logic                 entry_found;
		logic                 table_full;
		logic [REMOVED_W-1:0] removed_count;
	} result_t;

endpackage

// ----- rtl/kfwrl_if.sv -----
// request and response channel interfaces of the rate limiter
interface kfwrl_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic [kfwrl_pkg::USER_W-1:0]  user_id;
	logic [kfwrl_pkg::CHAN_W-1:0]  channel_id;
	logic [kfwrl_pkg::TIME_W-1:0]  now_seconds;
	logic [kfwrl_pkg::LIMIT_W-1:0] limit_count;
	logic [kfwrl_pkg::WIN_W-1:0]   window_seconds;
	logic                          mode_on;
	logic                          is_local;
	logic                          is_exempt;

	modport source (
		output valid, command, user_id, channel_id, now_seconds, limit_count,
			window_seconds, mode_on, is_local, is_exempt,
		input  ready
	);
	modport sink (
		input  valid, command, user_id, channel_id, now_seconds, limit_count,
			window_seconds, mode_on, is_local, is_exempt,
		output ready
	);
endinterface

interface kfwrl_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            throttled;
	logic                            entry_found;
	logic                            table_full;
	logic [kfwrl_pkg::REMOVED_W-1:0] removed_count;

	modport source (
		output valid, throttled, entry_found, table_full, removed_count,
		input  ready
	);
	modport sink (
		input  valid, throttled, entry_found, table_full, removed_count,
		output ready
	);
endinterface

// ----- rtl/kfwrl_front.sv -----
// front stage: accepts request items, clamps operands and classifies them
module kfwrl_front (
	input  logic            clk,
	input  logic            arst_n,
	kfwrl_req_if.sink       req,
	output kfwrl_pkg::job_t job,
	output logic            job_valid,
	input  logic            job_ready
);

	kfwrl_pkg::job_t job_d;
	kfwrl_pkg::job_t job_s1;
	logic            valid_s1;
	logic            accept;

	assign req.ready = !valid_s1 || job_ready;
	assign accept    = req.valid && req.ready;

	always_comb begin
		job_d.cmd         = kfwrl_pkg::cmd_t'(req.command);
		job_d.user        = req.user_id;
		job_d.chan        = req.channel_id;
		job_d.now         = req.now_seconds;
		job_d.limit       = (req.limit_count == '0) ? kfwrl_pkg::LIMIT_MIN : req.limit_count;
		job_d.throttle_en = req.mode_on && req.is_local && !req.is_exempt;
		job_d.record_en   = req.mode_on && req.is_local;
		job_d.sweep_hold  = req.mode_on;
		priority if (req.window_seconds == '0) begin
			job_d.win = kfwrl_pkg::WINDOW_MIN;
		end else if (req.window_seconds > kfwrl_pkg::WINDOW_MAX) begin
			job_d.win = kfwrl_pkg::WINDOW_MAX;
		end else begin
			job_d.win = req.window_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
		end
	end

	assign job       = job_s1;
	assign job_valid = valid_s1;

endmodule

// ----- rtl/kfwrl_queue.sv -----
// short queue of classified items between front and engine
module kfwrl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  kfwrl_pkg::job_t push_data,
	input  logic            push_valid,
	output logic            push_ready,
	output kfwrl_pkg::job_t pop_data,
	output logic            pop_valid,
	input  logic            pop_ready
);

	kfwrl_pkg::job_t                slot_q [kfwrl_pkg::QUEUE_DEPTH];
	logic [kfwrl_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [kfwrl_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [kfwrl_pkg::QCNT_W-1:0]   count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = count_q != kfwrl_pkg::QCNT_W'(kfwrl_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + kfwrl_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + kfwrl_pkg::QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + kfwrl_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - kfwrl_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/kfwrl_engine.sv -----
// back end: walks the entry table for each item and writes the result register
module kfwrl_engine #(
	parameter int ENTRIES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kfwrl_pkg::job_t job,
	input  logic            job_valid,
	output logic            job_pop,
	kfwrl_rsp_if.source     rsp
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(ENTRIES);

	kfwrl_pkg::entry_t     mem [ENTRIES];
	kfwrl_pkg::entry_t     rd_entry_s1;
	logic                  proc_valid_s1;
	logic [IDX_W-1:0]      proc_idx_s1;

	kfwrl_pkg::eng_state_t state_q, state_d;
	logic [CNT_W-1:0]      rd_cnt_q;
	kfwrl_pkg::job_t       job_q;

	logic                  found_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic                  match_inwin_q;
	logic [kfwrl_pkg::TIME_W-1:0]  match_start_q;
	logic [kfwrl_pkg::COUNT_W-1:0] match_cnt_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [kfwrl_pkg::REMOVED_W-1:0] removed_q;

	logic                  rsp_valid_q;
	kfwrl_pkg::result_t    rsp_q;
	kfwrl_pkg::result_t    rsp_d;
	logic                  load_rsp;

	logic                  rd_issue;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	kfwrl_pkg::entry_t     mem_wdata;

	logic [kfwrl_pkg::TIME_W-1:0] age;
	logic                  user_m;
	logic                  chan_m;
	logic                  in_win;
	logic                  hit;
	logic                  kill;

	// per-entry classification of the word read last cycle
	always_comb begin
		age    = job_q.now - rd_entry_s1.start;
		user_m = rd_entry_s1.user == job_q.user;
		chan_m = rd_entry_s1.chan == job_q.chan;
		in_win = age < kfwrl_pkg::TIME_W'(job_q.win);
		hit    = proc_valid_s1 && rd_entry_s1.valid && user_m && chan_m;
		unique case (job_q.cmd)
			kfwrl_pkg::CMD_SWEEP: kill = proc_valid_s1 && rd_entry_s1.valid && chan_m
				&& !(job_q.sweep_hold && in_win);
			kfwrl_pkg::CMD_DROP:  kill = proc_valid_s1 && rd_entry_s1.valid && user_m;
			default:              kill = 1'b0;
		endcase
	end

	always_comb begin
		rsp_d.throttled     = (job_q.cmd == kfwrl_pkg::CMD_CHECK) && found_q
			&& job_q.throttle_en && match_inwin_q
			&& (match_cnt_q == kfwrl_pkg::COUNT_W'(job_q.limit));
		rsp_d.entry_found   = ((job_q.cmd == kfwrl_pkg::CMD_CHECK)
			|| (job_q.cmd == kfwrl_pkg::CMD_RECORD)) && found_q;
		rsp_d.table_full    = (job_q.cmd == kfwrl_pkg::CMD_RECORD) && job_q.record_en
			&& !found_q && !free_found_q;
		rsp_d.removed_count = removed_q;
	end

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		rd_issue  = 1'b0;
		load_rsp  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		unique case (state_q)
			kfwrl_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = rd_cnt_q[IDX_W-1:0];
				if (rd_cnt_q == LAST_CNT) begin
					state_d = kfwrl_pkg::ST_IDLE;
				end
			end
			kfwrl_pkg::ST_IDLE: begin
				job_pop = job_valid;
				if (job_valid) begin
					state_d = kfwrl_pkg::ST_WALK;
				end
			end
			kfwrl_pkg::ST_WALK: begin
				rd_issue = rd_cnt_q != END_CNT;
				if (kill) begin
					mem_we          = 1'b1;
					mem_waddr       = proc_idx_s1;
					mem_wdata       = rd_entry_s1;
					mem_wdata.valid = 1'b0;
				end
				if (proc_valid_s1 && proc_idx_s1 == LAST_IDX) begin
					state_d = kfwrl_pkg::ST_UPDATE;
				end
			end
			kfwrl_pkg::ST_UPDATE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp        = 1'b1;
					state_d         = kfwrl_pkg::ST_IDLE;
					mem_wdata.valid = 1'b1;
					mem_wdata.user  = job_q.user;
					mem_wdata.chan  = job_q.chan;
					mem_wdata.start = job_q.now;
					mem_wdata.count = kfwrl_pkg::COUNT_ONE;
					if (job_q.cmd == kfwrl_pkg::CMD_RECORD && job_q.record_en) begin
						priority if (!found_q) begin
							mem_we    = free_found_q;
							mem_waddr = free_idx_q;
						end else if (match_inwin_q) begin
							mem_we          = 1'b1;
							mem_waddr       = match_idx_q;
							mem_wdata.start = match_start_q;
							mem_wdata.count = match_cnt_q + kfwrl_pkg::COUNT_ONE;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = match_idx_q;
						end
					end
				end
			end
			default: state_d = kfwrl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= kfwrl_pkg::ST_CLEAR;
			rd_cnt_q      <= '0;
			proc_valid_s1 <= 1'b0;
			found_q       <= 1'b0;
			free_found_q  <= 1'b0;
			removed_q     <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			proc_valid_s1 <= rd_issue;
			if (state_q == kfwrl_pkg::ST_CLEAR || rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			if (job_pop) begin
				rd_cnt_q     <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				removed_q    <= '0;
			end
			if (hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (proc_valid_s1 && !rd_entry_s1.valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (kill && removed_q != kfwrl_pkg::REMOVED_MAX) begin
				removed_q <= removed_q + kfwrl_pkg::REMOVED_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		proc_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (job_pop) begin
			job_q <= job;
		end
		if (hit && !found_q) begin
			match_idx_q   <= proc_idx_s1;
			match_inwin_q <= in_win;
			match_start_q <= rd_entry_s1.start;
			match_cnt_q   <= rd_entry_s1.count;
		end
		if (proc_valid_s1 && !rd_entry_s1.valid && !free_found_q) begin
			free_idx_q <= proc_idx_s1;
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	// entry table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_issue) begin
			rd_entry_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.throttled     = rsp_q.throttled;
	assign rsp.entry_found   = rsp_q.entry_found;
	assign rsp.table_full    = rsp_q.table_full;
	assign rsp.removed_count = rsp_q.removed_count;

endmodule

// ----- rtl/keyed_fixed_window_rate_limiter_unit.sv -----
// top level of the keyed fixed-window rate limiter
// the engine walks the table one entry per cycle and takes a new item only after loading the last result
// the front stage and queue take up to three more items while the walk runs
// after reset a clearing pass writes every table entry invalid before the first item runs
`include "keyed_fixed_window_rate_limiter_unit_assert.svh"

module keyed_fixed_window_rate_limiter_unit #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	kfwrl_req_if.sink   req,
	kfwrl_rsp_if.source rsp
);

	kfwrl_pkg::job_t front_job;
	logic            front_valid;
	logic            front_ready;
	kfwrl_pkg::job_t q_job;
	logic            q_valid;
	logic            q_pop;

	kfwrl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	kfwrl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (q_job),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop)
	);

	kfwrl_engine #(
		.ENTRIES (ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_job),
		.job_valid (q_valid),
		.job_pop   (q_pop),
		.rsp       (rsp)
	);

	`KFWRL_ASSERT_NEXT(a_one_walk_at_a_time, q_pop, !q_pop, "engine took two items back to back")
	`KFWRL_ASSERT_NOW(a_full_means_no_match, rsp.valid && rsp.table_full,
		!rsp.entry_found && !rsp.throttled && rsp.removed_count == '0,
		"table full reported together with a match")
	`KFWRL_ASSERT_NOW(a_removal_only_alone, rsp.valid && rsp.removed_count != '0,
		!rsp.entry_found && !rsp.throttled && !rsp.table_full,
		"removal count mixed with lookup flags")

endmodule
